// File: src/tphb_pkg.sv
`timescale 1ns / 1ps

package tphb_pkg;

   // register file of the configuration port
   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DT_OVER_CAP,
      CSR_DT_OVER_IND,
      CSR_SERIES_RES,
      CSR_CAP_COND
   } csr_index_type;

   // default capacitor companion conductance, integer part
   localparam int unsigned CAP_G_DEFAULT = 10000;

   // multiplier pipeline depth, start to product
   localparam int MUL_LATENCY = 5;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MUL_WAIT,
      ST_COMMIT
   } state_type;

   // step operations
   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL
   } op_type;

   // operand sources
   typedef enum logic [5:0] {
      SRC_ZERO,
      SRC_EPOS, SRC_ENEU, SRC_ENEG,
      SRC_EPH1, SRC_EPH2, SRC_EPH3,
      SRC_VC1, SRC_VC2,
      SRC_IL1, SRC_IL2, SRC_IL3,
      SRC_X1, SRC_X2, SRC_X3,
      SRC_U1, SRC_U2, SRC_U3,
      SRC_D1, SRC_D2, SRC_D3,
      SRC_G, SRC_DCAP, SRC_DIND, SRC_RSER,
      SRC_ACC, SRC_TMP, SRC_IPOS, SRC_INEG,
      SRC_V1, SRC_V2, SRC_BP, SRC_BN
   } src_type;

   // result destinations
   typedef enum logic [3:0] {
      DST_ACC, DST_TMP, DST_IPOS, DST_INEG,
      DST_N1, DST_N2, DST_N3,
      DST_V1, DST_V2,
      DST_BP, DST_BN, DST_BU
   } dst_type;

   typedef struct packed {
      op_type  op;
      src_type src_a;
      src_type src_b;
      dst_type dst;
      logic    last;
   } uop_type;

   localparam int UOP_COUNT = 38;
   localparam int PC_BITS   = 6;

   typedef logic [PC_BITS-1:0] pc_type;

   // controller to datapath
   typedef struct packed {
      logic    load_item;
      logic    alu_wr;
      logic    mul_start;
      logic    mul_wr;
      logic    commit;
      uop_type uop;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic mul_done;
   } status_type;

   // step program: capacitor branch currents, three legs, capacitors, injections
   function automatic uop_type uop_rom(input pc_type pc);
      uop_type u;
      unique case (pc)
         // upper capacitor branch current
         6'd0:  u = '{OP_SUB, SRC_EPOS, SRC_VC1,  DST_ACC,  1'b0};
         6'd1:  u = '{OP_SUB, SRC_ACC,  SRC_ENEU, DST_ACC,  1'b0};
         6'd2:  u = '{OP_MUL, SRC_G,    SRC_ACC,  DST_IPOS, 1'b0};
         // lower capacitor branch current
         6'd3:  u = '{OP_SUB, SRC_ENEG, SRC_VC2,  DST_ACC,  1'b0};
         6'd4:  u = '{OP_SUB, SRC_ACC,  SRC_ENEU, DST_ACC,  1'b0};
         6'd5:  u = '{OP_MUL, SRC_G,    SRC_ACC,  DST_INEG, 1'b0};
         // leg one
         6'd6:  u = '{OP_ADD, SRC_X1,   SRC_ENEU, DST_ACC,  1'b0};
         6'd7:  u = '{OP_SUB, SRC_ACC,  SRC_EPH1, DST_ACC,  1'b0};
         6'd8:  u = '{OP_MUL, SRC_RSER, SRC_IL1,  DST_TMP,  1'b0};
         6'd9:  u = '{OP_SUB, SRC_ACC,  SRC_TMP,  DST_ACC,  1'b0};
         6'd10: u = '{OP_MUL, SRC_DIND, SRC_ACC,  DST_TMP,  1'b0};
         6'd11: u = '{OP_ADD, SRC_IL1,  SRC_TMP,  DST_N1,   1'b0};
         // leg two
         6'd12: u = '{OP_ADD, SRC_X2,   SRC_ENEU, DST_ACC,  1'b0};
         6'd13: u = '{OP_SUB, SRC_ACC,  SRC_EPH2, DST_ACC,  1'b0};
         6'd14: u = '{OP_MUL, SRC_RSER, SRC_IL2,  DST_TMP,  1'b0};
         6'd15: u = '{OP_SUB, SRC_ACC,  SRC_TMP,  DST_ACC,  1'b0};
         6'd16: u = '{OP_MUL, SRC_DIND, SRC_ACC,  DST_TMP,  1'b0};
         6'd17: u = '{OP_ADD, SRC_IL2,  SRC_TMP,  DST_N2,   1'b0};
         // leg three
         6'd18: u = '{OP_ADD, SRC_X3,   SRC_ENEU, DST_ACC,  1'b0};
         6'd19: u = '{OP_SUB, SRC_ACC,  SRC_EPH3, DST_ACC,  1'b0};
         6'd20: u = '{OP_MUL, SRC_RSER, SRC_IL3,  DST_TMP,  1'b0};
         6'd21: u = '{OP_SUB, SRC_ACC,  SRC_TMP,  DST_ACC,  1'b0};
         6'd22: u = '{OP_MUL, SRC_DIND, SRC_ACC,  DST_TMP,  1'b0};
         6'd23: u = '{OP_ADD, SRC_IL3,  SRC_TMP,  DST_N3,   1'b0};
         // upper capacitor
         6'd24: u = '{OP_SUB, SRC_IPOS, SRC_U1,   DST_ACC,  1'b0};
         6'd25: u = '{OP_SUB, SRC_ACC,  SRC_U2,   DST_ACC,  1'b0};
         6'd26: u = '{OP_SUB, SRC_ACC,  SRC_U3,   DST_ACC,  1'b0};
         6'd27: u = '{OP_MUL, SRC_DCAP, SRC_ACC,  DST_TMP,  1'b0};
         6'd28: u = '{OP_ADD, SRC_TMP,  SRC_VC1,  DST_V1,   1'b0};
         // lower capacitor
         6'd29: u = '{OP_SUB, SRC_INEG, SRC_D1,   DST_ACC,  1'b0};
         6'd30: u = '{OP_SUB, SRC_ACC,  SRC_D2,   DST_ACC,  1'b0};
         6'd31: u = '{OP_SUB, SRC_ACC,  SRC_D3,   DST_ACC,  1'b0};
         6'd32: u = '{OP_MUL, SRC_DCAP, SRC_ACC,  DST_TMP,  1'b0};
         6'd33: u = '{OP_ADD, SRC_TMP,  SRC_VC2,  DST_V2,   1'b0};
         // companion source currents
         6'd34: u = '{OP_MUL, SRC_V1,   SRC_G,    DST_BP,   1'b0};
         6'd35: u = '{OP_MUL, SRC_V2,   SRC_G,    DST_BN,   1'b0};
         6'd36: u = '{OP_SUB, SRC_ZERO, SRC_BP,   DST_ACC,  1'b0};
         6'd37: u = '{OP_SUB, SRC_ACC,  SRC_BN,   DST_BU,   1'b1};
         default: u = '{OP_ADD, SRC_ZERO, SRC_ZERO, DST_ACC, 1'b1};
      endcase
      return u;
   endfunction

endpackage

// File: src/tphb_req_if.sv
`timescale 1ns / 1ps

interface tphb_req_if #(
   parameter int WORD_BITS = 48
) ();
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] v_pos_rail;
   logic signed [WORD_BITS-1:0] v_neutral;
   logic signed [WORD_BITS-1:0] v_neg_rail;
   logic signed [WORD_BITS-1:0] v_phase_1;
   logic signed [WORD_BITS-1:0] v_phase_2;
   logic signed [WORD_BITS-1:0] v_phase_3;
   logic                        gate_1;
   logic                        gate_2;
   logic                        gate_3;
   logic                        gates_enabled;

   modport source (
      output valid, v_pos_rail, v_neutral, v_neg_rail, v_phase_1, v_phase_2, v_phase_3,
      output gate_1, gate_2, gate_3, gates_enabled,
      input  ready
   );

   modport sink (
      input  valid, v_pos_rail, v_neutral, v_neg_rail, v_phase_1, v_phase_2, v_phase_3,
      input  gate_1, gate_2, gate_3, gates_enabled,
      output ready
   );
endinterface

// File: src/tphb_rsp_if.sv
`timescale 1ns / 1ps

interface tphb_rsp_if #(
   parameter int WORD_BITS = 48
) ();
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] inj_pos_rail;
   logic signed [WORD_BITS-1:0] inj_neutral;
   logic signed [WORD_BITS-1:0] inj_neg_rail;
   logic signed [WORD_BITS-1:0] inj_phase_1;
   logic signed [WORD_BITS-1:0] inj_phase_2;
   logic signed [WORD_BITS-1:0] inj_phase_3;
   logic signed [WORD_BITS-1:0] cap_volt_pos_out;
   logic signed [WORD_BITS-1:0] cap_volt_neg_out;

   modport source (
      output valid, inj_pos_rail, inj_neutral, inj_neg_rail,
      output inj_phase_1, inj_phase_2, inj_phase_3, cap_volt_pos_out, cap_volt_neg_out,
      input  ready
   );

   modport sink (
      input  valid, inj_pos_rail, inj_neutral, inj_neg_rail,
      input  inj_phase_1, inj_phase_2, inj_phase_3, cap_volt_pos_out, cap_volt_neg_out,
      output ready
   );
endinterface

// File: src/tphb_mul.sv
`timescale 1ns / 1ps

// pipelined signed fixed-point multiplier: four half-word partial products,
// floor rounding after the fraction shift, saturation to the word range
module tphb_mul #(
   parameter int WORD_BITS = 48,
   parameter int FRAC_BITS = 24
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [WORD_BITS-1:0] a,
   input  logic signed [WORD_BITS-1:0] b,
   output logic                        done,
   output logic signed [WORD_BITS-1:0] product
);
   localparam int W  = WORD_BITS;
   localparam int H  = (W + 1) / 2;
   localparam int MW = 2 * H;
   localparam int PW = 4 * H;

   localparam logic [PW-1:0] LIM     = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic [PW-1:0] LIM_NEG = LIM + PW'(1);
   localparam logic [PW-1:0] BIAS    = PW'({FRAC_BITS{1'b1}});
   localparam logic [W-1:0]  SMAX    = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]  SMIN    = {1'b1, {(W-1){1'b0}}};

   logic [MW-1:0]        mag_a_ff, mag_a_in, mag_b_ff, mag_b_in;
   logic [3:0]           neg_ff, neg_in;
   logic [4:0]           vld_ff, vld_in;
   logic [2*H-1:0]       ll_ff, ll_in, lh_ff, lh_in, hl_ff, hl_in, hh_ff, hh_in;
   logic [2*H:0]         mid_ff, mid_in;
   logic [PW-1:0]        cross_ff, cross_in;
   logic [PW-1:0]        full_ff, full_in;
   logic [W-1:0]         prod_ff, prod_in;
   logic [W-1:0]         a_u, b_u;
   logic [PW-1:0]        rnd, quo;
   logic [W-1:0]         quo_neg;

   // stage a: magnitudes and product sign
   always_comb begin
      a_u      = a;
      b_u      = b;
      mag_a_in = MW'(a_u[W-1] ? (~a_u + W'(1)) : a_u);
      mag_b_in = MW'(b_u[W-1] ? (~b_u + W'(1)) : b_u);
   end

   // stage b: partial products
   always_comb begin
      ll_in = mag_a_ff[H-1:0]  * mag_b_ff[H-1:0];
      lh_in = mag_a_ff[H-1:0]  * mag_b_ff[MW-1:H];
      hl_in = mag_a_ff[MW-1:H] * mag_b_ff[H-1:0];
      hh_in = mag_a_ff[MW-1:H] * mag_b_ff[MW-1:H];
   end

   // stage c: middle sum, outer terms side by side
   always_comb begin
      mid_in   = (2*H+1)'(lh_ff) + (2*H+1)'(hl_ff);
      cross_in = {hh_ff, ll_ff};
   end

   // stage d: full magnitude product
   always_comb begin
      full_in = cross_ff + (PW'(mid_ff) << H);
   end

   // stage e: floor shift and saturate
   always_comb begin
      rnd     = full_ff + (neg_ff[3] ? BIAS : '0);
      quo     = rnd >> FRAC_BITS;
      quo_neg = ~quo[W-1:0] + W'(1);
      priority if (!neg_ff[3]) begin
         prod_in = (quo > LIM) ? SMAX : quo[W-1:0];
      end else begin
         prod_in = (quo > LIM_NEG) ? SMIN : quo_neg;
      end
   end

   // sign and valid travel along the stages
   always_comb begin
      neg_in = {neg_ff[2:0], a[W-1] ^ b[W-1]};
      vld_in = {vld_ff[3:0], start};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff   <= neg_in;
      mag_a_ff <= mag_a_in;
      mag_b_ff <= mag_b_in;
      ll_ff    <= ll_in;
      lh_ff    <= lh_in;
      hl_ff    <= hl_in;
      hh_ff    <= hh_in;
      mid_ff   <= mid_in;
      cross_ff <= cross_in;
      full_ff  <= full_in;
      prod_ff  <= prod_in;
   end

   assign done    = vld_ff[4];
   assign product = prod_ff;

endmodule

// File: src/tphb_datapath.sv
`timescale 1ns / 1ps

module tphb_datapath #(
   parameter int WORD_BITS = 48,
   parameter int FRAC_BITS = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration writes
   input  logic                                   csr_wen,
   input  logic [tphb_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [WORD_BITS-2:0]                   csr_wdata,
   // incoming word
   input  logic signed [WORD_BITS-1:0]            v_pos_rail,
   input  logic signed [WORD_BITS-1:0]            v_neutral,
   input  logic signed [WORD_BITS-1:0]            v_neg_rail,
   input  logic signed [WORD_BITS-1:0]            v_phase_1,
   input  logic signed [WORD_BITS-1:0]            v_phase_2,
   input  logic signed [WORD_BITS-1:0]            v_phase_3,
   input  logic                                   gate_1,
   input  logic                                   gate_2,
   input  logic                                   gate_3,
   input  logic                                   gates_enabled,
   // control
   input  tphb_pkg::cmd_type                      cmd,
   output tphb_pkg::status_type                   status,
   // result word
   output logic signed [WORD_BITS-1:0]            inj_pos_rail,
   output logic signed [WORD_BITS-1:0]            inj_neutral,
   output logic signed [WORD_BITS-1:0]            inj_neg_rail,
   output logic signed [WORD_BITS-1:0]            inj_phase_1,
   output logic signed [WORD_BITS-1:0]            inj_phase_2,
   output logic signed [WORD_BITS-1:0]            inj_phase_3,
   output logic signed [WORD_BITS-1:0]            cap_volt_pos_out,
   output logic signed [WORD_BITS-1:0]            cap_volt_neg_out
);
   localparam int W  = WORD_BITS;
   localparam int GW = W + FRAC_BITS + 14;

   localparam logic [W-1:0]  SMAX    = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]  SMIN    = {1'b1, {(W-1){1'b0}}};
   localparam logic [GW-1:0] G_FULL  = GW'(tphb_pkg::CAP_G_DEFAULT) << FRAC_BITS;
   localparam logic [GW-1:0] C_MAX   = GW'({(W-1){1'b1}});
   localparam logic [W-2:0]  G_RESET = (G_FULL > C_MAX) ? {(W-1){1'b1}} : G_FULL[W-2:0];

   typedef logic signed [W-1:0] word_type;

   typedef struct packed {
      word_type x;
      word_type u;
      word_type d;
   } leg_sel_type;

   typedef struct packed {
      word_type epos, eneu, eneg, eph1, eph2, eph3;
      word_type vc1, vc2, il1, il2, il3;
      word_type x1, x2, x3, u1, u2, u3, d1, d2, d3;
      word_type g, dcap, dind, rser;
      word_type acc, tmp, ipos, ineg, v1, v2, bp, bn;
   } opnd_type;

   // configuration registers
   logic [W-2:0] dcap_ff, dcap_in, dind_ff, dind_in, rser_ff, rser_in, capg_ff, capg_in;

   // latched word
   word_type epos_ff, epos_in, eneu_ff, eneu_in, eneg_ff, eneg_in;
   word_type eph1_ff, eph1_in, eph2_ff, eph2_in, eph3_ff, eph3_in;
   logic     gate1_ff, gate1_in, gate2_ff, gate2_in, gate3_ff, gate3_in, en_ff, en_in;

   // converter state
   word_type il1_ff, il1_in, il2_ff, il2_in, il3_ff, il3_in, vc1_ff, vc1_in, vc2_ff, vc2_in;

   // step temporaries
   word_type acc_ff, acc_in, tmp_ff, tmp_in, ipos_ff, ipos_in, ineg_ff, ineg_in;
   word_type n1_ff, n1_in, n2_ff, n2_in, n3_ff, n3_in, v1_ff, v1_in, v2_ff, v2_in;
   word_type bp_ff, bp_in, bn_ff, bn_in, bu_ff, bu_in;

   // result registers
   word_type o_pos_ff, o_pos_in, o_neu_ff, o_neu_in, o_neg_ff, o_neg_in;
   word_type o_ph1_ff, o_ph1_in, o_ph2_ff, o_ph2_in, o_ph3_ff, o_ph3_in;
   word_type o_vc1_ff, o_vc1_in, o_vc2_ff, o_vc2_in;

   leg_sel_type sel1, sel2, sel3;
   opnd_type    opnd;
   word_type    opa, opb, alu_res, mul_prod, wr_data;
   logic [W:0]  ext_a, ext_b, wide;
   logic        mul_done;

   // switch or diode path of one leg
   function automatic leg_sel_type leg_sel(input logic en, input logic gate,
                                           input word_type il, input word_type eph,
                                           input word_type vc1, input word_type vc2);
      leg_sel_type s;
      priority if (en && gate) begin
         s = '{vc1, il, '0};
      end else if (en) begin
         s = '{vc2, '0, il};
      end else if (!il[W-1] && (il != '0)) begin
         // diode to the lower rail, draw kept negated
         s = '{vc2, '0, word_type'(~il + W'(1))};
      end else if (il[W-1]) begin
         s = '{vc1, il, '0};
      end else begin
         s = '{eph, '0, '0};
      end
      return s;
   endfunction

   function automatic word_type pick(input tphb_pkg::src_type s, input opnd_type v);
      word_type r;
      unique case (s)
         tphb_pkg::SRC_ZERO: r = '0;
         tphb_pkg::SRC_EPOS: r = v.epos;
         tphb_pkg::SRC_ENEU: r = v.eneu;
         tphb_pkg::SRC_ENEG: r = v.eneg;
         tphb_pkg::SRC_EPH1: r = v.eph1;
         tphb_pkg::SRC_EPH2: r = v.eph2;
         tphb_pkg::SRC_EPH3: r = v.eph3;
         tphb_pkg::SRC_VC1:  r = v.vc1;
         tphb_pkg::SRC_VC2:  r = v.vc2;
         tphb_pkg::SRC_IL1:  r = v.il1;
         tphb_pkg::SRC_IL2:  r = v.il2;
         tphb_pkg::SRC_IL3:  r = v.il3;
         tphb_pkg::SRC_X1:   r = v.x1;
         tphb_pkg::SRC_X2:   r = v.x2;
         tphb_pkg::SRC_X3:   r = v.x3;
         tphb_pkg::SRC_U1:   r = v.u1;
         tphb_pkg::SRC_U2:   r = v.u2;
         tphb_pkg::SRC_U3:   r = v.u3;
         tphb_pkg::SRC_D1:   r = v.d1;
         tphb_pkg::SRC_D2:   r = v.d2;
         tphb_pkg::SRC_D3:   r = v.d3;
         tphb_pkg::SRC_G:    r = v.g;
         tphb_pkg::SRC_DCAP: r = v.dcap;
         tphb_pkg::SRC_DIND: r = v.dind;
         tphb_pkg::SRC_RSER: r = v.rser;
         tphb_pkg::SRC_ACC:  r = v.acc;
         tphb_pkg::SRC_TMP:  r = v.tmp;
         tphb_pkg::SRC_IPOS: r = v.ipos;
         tphb_pkg::SRC_INEG: r = v.ineg;
         tphb_pkg::SRC_V1:   r = v.v1;
         tphb_pkg::SRC_V2:   r = v.v2;
         tphb_pkg::SRC_BP:   r = v.bp;
         tphb_pkg::SRC_BN:   r = v.bn;
         default:            r = '0;
      endcase
      return r;
   endfunction

   // configuration writes
   always_comb begin
      dcap_in = dcap_ff;
      dind_in = dind_ff;
      rser_in = rser_ff;
      capg_in = capg_ff;
      if (csr_wen) begin
         unique case (tphb_pkg::csr_index_type'(csr_index))
            tphb_pkg::CSR_DT_OVER_CAP: dcap_in = csr_wdata;
            tphb_pkg::CSR_DT_OVER_IND: dind_in = csr_wdata;
            tphb_pkg::CSR_SERIES_RES:  rser_in = csr_wdata;
            tphb_pkg::CSR_CAP_COND:    capg_in = csr_wdata;
         endcase
      end
   end

   // word capture
   always_comb begin
      epos_in  = cmd.load_item ? v_pos_rail    : epos_ff;
      eneu_in  = cmd.load_item ? v_neutral     : eneu_ff;
      eneg_in  = cmd.load_item ? v_neg_rail    : eneg_ff;
      eph1_in  = cmd.load_item ? v_phase_1     : eph1_ff;
      eph2_in  = cmd.load_item ? v_phase_2     : eph2_ff;
      eph3_in  = cmd.load_item ? v_phase_3     : eph3_ff;
      gate1_in = cmd.load_item ? gate_1        : gate1_ff;
      gate2_in = cmd.load_item ? gate_2        : gate2_ff;
      gate3_in = cmd.load_item ? gate_3        : gate3_ff;
      en_in    = cmd.load_item ? gates_enabled : en_ff;
   end

   // leg paths from the state held before this step
   always_comb begin
      sel1 = leg_sel(en_ff, gate1_ff, il1_ff, eph1_ff, vc1_ff, vc2_ff);
      sel2 = leg_sel(en_ff, gate2_ff, il2_ff, eph2_ff, vc1_ff, vc2_ff);
      sel3 = leg_sel(en_ff, gate3_ff, il3_ff, eph3_ff, vc1_ff, vc2_ff);
   end

   // operand selection
   always_comb begin
      opnd = '{epos_ff, eneu_ff, eneg_ff, eph1_ff, eph2_ff, eph3_ff,
               vc1_ff, vc2_ff, il1_ff, il2_ff, il3_ff,
               sel1.x, sel2.x, sel3.x, sel1.u, sel2.u, sel3.u, sel1.d, sel2.d, sel3.d,
               word_type'({1'b0, capg_ff}), word_type'({1'b0, dcap_ff}),
               word_type'({1'b0, dind_ff}), word_type'({1'b0, rser_ff}),
               acc_ff, tmp_ff, ipos_ff, ineg_ff, v1_ff, v2_ff, bp_ff, bn_ff};
      opa  = pick(cmd.uop.src_a, opnd);
      opb  = pick(cmd.uop.src_b, opnd);
   end

   // saturating add and subtract
   always_comb begin
      ext_a = {opa[W-1], opa};
      ext_b = {opb[W-1], opb};
      priority if (cmd.uop.op == tphb_pkg::OP_SUB) begin
         wide = ext_a - ext_b;
      end else begin
         wide = ext_a + ext_b;
      end
      priority if (wide[W] != wide[W-1]) begin
         alu_res = wide[W] ? SMIN : SMAX;
      end else begin
         alu_res = wide[W-1:0];
      end
   end

   tphb_mul #(
      .WORD_BITS (WORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .a       (opa),
      .b       (opb),
      .done    (mul_done),
      .product (mul_prod)
   );

   assign status.mul_done = mul_done;

   // temporary write-back
   always_comb begin
      wr_data = cmd.mul_wr ? mul_prod : alu_res;
      acc_in  = acc_ff;
      tmp_in  = tmp_ff;
      ipos_in = ipos_ff;
      ineg_in = ineg_ff;
      n1_in   = n1_ff;
      n2_in   = n2_ff;
      n3_in   = n3_ff;
      v1_in   = v1_ff;
      v2_in   = v2_ff;
      bp_in   = bp_ff;
      bn_in   = bn_ff;
      bu_in   = bu_ff;
      if (cmd.alu_wr || cmd.mul_wr) begin
         unique case (cmd.uop.dst)
            tphb_pkg::DST_ACC:  acc_in  = wr_data;
            tphb_pkg::DST_TMP:  tmp_in  = wr_data;
            tphb_pkg::DST_IPOS: ipos_in = wr_data;
            tphb_pkg::DST_INEG: ineg_in = wr_data;
            tphb_pkg::DST_N1:   n1_in   = wr_data;
            tphb_pkg::DST_N2:   n2_in   = wr_data;
            tphb_pkg::DST_N3:   n3_in   = wr_data;
            tphb_pkg::DST_V1:   v1_in   = wr_data;
            tphb_pkg::DST_V2:   v2_in   = wr_data;
            tphb_pkg::DST_BP:   bp_in   = wr_data;
            tphb_pkg::DST_BN:   bn_in   = wr_data;
            tphb_pkg::DST_BU:   bu_in   = wr_data;
            default:            acc_in  = acc_ff;
         endcase
      end
   end

   // step commit: new state and result word
   always_comb begin
      il1_in   = cmd.commit ? n1_ff : il1_ff;
      il2_in   = cmd.commit ? n2_ff : il2_ff;
      il3_in   = cmd.commit ? n3_ff : il3_ff;
      vc1_in   = cmd.commit ? v1_ff : vc1_ff;
      vc2_in   = cmd.commit ? v2_ff : vc2_ff;
      o_pos_in = cmd.commit ? bp_ff : o_pos_ff;
      o_neu_in = cmd.commit ? bu_ff : o_neu_ff;
      o_neg_in = cmd.commit ? bn_ff : o_neg_ff;
      o_ph1_in = cmd.commit ? n1_ff : o_ph1_ff;
      o_ph2_in = cmd.commit ? n2_ff : o_ph2_ff;
      o_ph3_in = cmd.commit ? n3_ff : o_ph3_ff;
      o_vc1_in = cmd.commit ? v1_ff : o_vc1_ff;
      o_vc2_in = cmd.commit ? v2_ff : o_vc2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dcap_ff <= '0;
         dind_ff <= '0;
         rser_ff <= '0;
         capg_ff <= G_RESET;
         il1_ff  <= '0;
         il2_ff  <= '0;
         il3_ff  <= '0;
         vc1_ff  <= '0;
         vc2_ff  <= '0;
      end else begin
         dcap_ff <= dcap_in;
         dind_ff <= dind_in;
         rser_ff <= rser_in;
         capg_ff <= capg_in;
         il1_ff  <= il1_in;
         il2_ff  <= il2_in;
         il3_ff  <= il3_in;
         vc1_ff  <= vc1_in;
         vc2_ff  <= vc2_in;
      end
   end

   always_ff @(posedge clock) begin
      epos_ff  <= epos_in;
      eneu_ff  <= eneu_in;
      eneg_ff  <= eneg_in;
      eph1_ff  <= eph1_in;
      eph2_ff  <= eph2_in;
      eph3_ff  <= eph3_in;
      gate1_ff <= gate1_in;
      gate2_ff <= gate2_in;
      gate3_ff <= gate3_in;
      en_ff    <= en_in;
      acc_ff   <= acc_in;
      tmp_ff   <= tmp_in;
      ipos_ff  <= ipos_in;
      ineg_ff  <= ineg_in;
      n1_ff    <= n1_in;
      n2_ff    <= n2_in;
      n3_ff    <= n3_in;
      v1_ff    <= v1_in;
      v2_ff    <= v2_in;
      bp_ff    <= bp_in;
      bn_ff    <= bn_in;
      bu_ff    <= bu_in;
      o_pos_ff <= o_pos_in;
      o_neu_ff <= o_neu_in;
      o_neg_ff <= o_neg_in;
      o_ph1_ff <= o_ph1_in;
      o_ph2_ff <= o_ph2_in;
      o_ph3_ff <= o_ph3_in;
      o_vc1_ff <= o_vc1_in;
      o_vc2_ff <= o_vc2_in;
   end

   assign inj_pos_rail     = o_pos_ff;
   assign inj_neutral      = o_neu_ff;
   assign inj_neg_rail     = o_neg_ff;
   assign inj_phase_1      = o_ph1_ff;
   assign inj_phase_2      = o_ph2_ff;
   assign inj_phase_3      = o_ph3_ff;
   assign cap_volt_pos_out = o_vc1_ff;
   assign cap_volt_neg_out = o_vc2_ff;

endmodule

// File: src/tphb_ctrl.sv
`timescale 1ns / 1ps

// step sequencer: walks the step program, one add/sub per cycle,
// waits on the shared multiplier, then commits into the result register
module tphb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tphb_pkg::cmd_type    cmd,
   input  tphb_pkg::status_type status
);
   tphb_pkg::state_type state_ff, state_in;
   tphb_pkg::pc_type    pc_ff, pc_in;
   tphb_pkg::uop_type   uop;
   logic                out_valid_ff, out_valid_in;
   logic                out_free;

   assign uop      = tphb_pkg::uop_rom(pc_ff);
   assign out_free = !out_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      unique case (state_ff)
         tphb_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = tphb_pkg::ST_EXEC;
               pc_in    = '0;
            end
         end
         tphb_pkg::ST_EXEC: begin
            priority if (uop.op == tphb_pkg::OP_MUL) begin
               state_in = tphb_pkg::ST_MUL_WAIT;
            end else if (uop.last) begin
               state_in = tphb_pkg::ST_COMMIT;
            end else begin
               pc_in = pc_ff + tphb_pkg::pc_type'(1);
            end
         end
         tphb_pkg::ST_MUL_WAIT: begin
            if (status.mul_done) begin
               priority if (uop.last) begin
                  state_in = tphb_pkg::ST_COMMIT;
               end else begin
                  state_in = tphb_pkg::ST_EXEC;
                  pc_in    = pc_ff + tphb_pkg::pc_type'(1);
               end
            end
         end
         tphb_pkg::ST_COMMIT: begin
            if (out_free) begin
               state_in = tphb_pkg::ST_IDLE;
            end
         end
         default: state_in = tphb_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready     = (state_ff == tphb_pkg::ST_IDLE);
      cmd.load_item = (state_ff == tphb_pkg::ST_IDLE) && req_valid;
      cmd.alu_wr    = (state_ff == tphb_pkg::ST_EXEC) && (uop.op != tphb_pkg::OP_MUL);
      cmd.mul_start = (state_ff == tphb_pkg::ST_EXEC) && (uop.op == tphb_pkg::OP_MUL);
      cmd.mul_wr    = (state_ff == tphb_pkg::ST_MUL_WAIT) && status.mul_done;
      cmd.commit    = (state_ff == tphb_pkg::ST_COMMIT) && out_free;
      cmd.uop       = uop;
   end

   // result word held until taken
   always_comb begin
      out_valid_in = cmd.commit || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tphb_pkg::ST_IDLE;
         pc_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

`ifndef ASSERT_OFF
   a_mul_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.mul_done |-> (state_ff == tphb_pkg::ST_MUL_WAIT))
      else $error("multiplier result outside the wait state");

   a_mul_latency: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |-> ##(tphb_pkg::MUL_LATENCY) status.mul_done)
      else $error("multiplier result late or missing");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tphb_pkg::ST_IDLE && req_valid) |=>
         (state_ff == tphb_pkg::ST_EXEC && pc_ff == '0))
      else $error("accepted word did not start the step program");

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff < tphb_pkg::pc_type'(tphb_pkg::UOP_COUNT))
      else $error("step counter past the program");
`endif

endmodule

// File: src/three_phase_half_bridge_step_unit.sv
`timescale 1ns / 1ps

// channel  | dir | handshake     | payload
// req_chan | in  | valid / ready | node voltages, three leg gates, gate enable
// rsp_chan | out | valid / ready | rail and neutral injections, leg currents, cap voltages
// csr      | in  | csr_wen       | csr_index selects the register, csr_wdata the value
//
// an accepted word runs 26 saturating add/sub steps and 12 multiplies on the one shared
// five-stage multiplier, each multiply waiting for its product, and then commits.
// a new word is taken only while the sequencer is idle; the finished word sits in the
// result register, so the next word runs while it waits, and commit stalls only if that
// register is still full. synchronous reset clears leg currents, capacitor voltages and
// registers (conductance to 10000.0) and empties the result register.
module three_phase_half_bridge_step_unit #(
   parameter int WORD_BITS = 48,
   parameter int FRAC_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   tphb_req_if.sink                            req_chan,
   tphb_rsp_if.source                          rsp_chan,
   input  logic                                csr_wen,
   input  logic [tphb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [WORD_BITS-2:0]                csr_wdata
);
   tphb_pkg::cmd_type    cmd;
   tphb_pkg::status_type status;

   tphb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   tphb_datapath #(
      .WORD_BITS (WORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wen          (csr_wen),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .v_pos_rail       (req_chan.v_pos_rail),
      .v_neutral        (req_chan.v_neutral),
      .v_neg_rail       (req_chan.v_neg_rail),
      .v_phase_1        (req_chan.v_phase_1),
      .v_phase_2        (req_chan.v_phase_2),
      .v_phase_3        (req_chan.v_phase_3),
      .gate_1           (req_chan.gate_1),
      .gate_2           (req_chan.gate_2),
      .gate_3           (req_chan.gate_3),
      .gates_enabled    (req_chan.gates_enabled),
      .cmd              (cmd),
      .status           (status),
      .inj_pos_rail     (rsp_chan.inj_pos_rail),
      .inj_neutral      (rsp_chan.inj_neutral),
      .inj_neg_rail     (rsp_chan.inj_neg_rail),
      .inj_phase_1      (rsp_chan.inj_phase_1),
      .inj_phase_2      (rsp_chan.inj_phase_2),
      .inj_phase_3      (rsp_chan.inj_phase_3),
      .cap_volt_pos_out (rsp_chan.cap_volt_pos_out),
      .cap_volt_neg_out (rsp_chan.cap_volt_neg_out)
   );

endmodule
